/* hw/rtl/mwdiv_pkg.sv */
// ----------------------------------------------------------------------------
// Multiword divider package
// Shared constants and configuration register indexes.
// ----------------------------------------------------------------------------
package mwdiv_pkg;
  localparam int WORD_BITS_DEF = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int SHIFT_W = 6;
  localparam int HALF_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECIPROCAL = 2'd2;
endpackage

/* hw/rtl/multiword_divide_by_word.sv */
// ----------------------------------------------------------------------------
// Multiword divide by word
// Long division of a streamed multiword number by a configured word divisor.
// ----------------------------------------------------------------------------
// Dividend words enter on the in channel (in_valid/in_ready), most
// significant first, with final_word set on the last one. Each word gives one
// result on the out channel (out_valid/out_ready): the quotient word, the
// running remainder and final_out.
// Every word uses one shared 32x32 multiplier under a small sequencer: four
// partial products of reciprocal*nh, an add step, four of q1*dn, then a
// correction step. A word passes through ST_MUL1, ST_ADD1, ST_MUL2, ST_FIX
// and ST_DONE in turn before its result goes to the output register. The
// block is not ready while a word is in work, and takes the next word in the
// cycle after its result is handed to the output register, even if the
// receiver stalls that result. With a stalled receiver, at most one result
// waits and a second finished word holds in the datapath.
// Reset clears the running remainder and sets divisor 1, shift 63 and
// reciprocal all ones. Configuration writes take effect at once; the user
// must make them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module multiword_divide_by_word #(
  parameter int WORD_BITS = mwdiv_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mwdiv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwdiv_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [WORD_BITS-1:0]                 dividend_word,
  input  logic                                 final_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [WORD_BITS-1:0]                 quotient_word,
  output logic [WORD_BITS-1:0]                 remainder,
  output logic                                 final_out
);
  import mwdiv_pkg::*;

  localparam int W = WORD_BITS;
  localparam int W2 = 2 * W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_ADD1 = 6'b000100,
    ST_MUL2 = 6'b001000,
    ST_FIX  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;
  logic [1:0] part;
  logic [W-1:0] divisor, reciprocal;
  logic [SHIFT_W-1:0] norm_shift;
  logic [W-1:0] run_rem;
  logic [W-1:0] nh, nl, dn, q1, q0;
  logic [W2-1:0] acc;
  logic [SHIFT_W-1:0] sh;
  logic fin;

  // Effective shift, clamped below the word width.
  logic [SHIFT_W-1:0] s_eff;
  always_comb begin
    if (32'(norm_shift) >= W) s_eff = SHIFT_W'(W - 1);
    else s_eff = norm_shift;
  end

  logic [W2-1:0] pre_cat, pre_sh;
  always_comb begin
    pre_cat = {run_rem, dividend_word};
    pre_sh = pre_cat << s_eff;
  end

  // Shared multiplier: operands split into two halves of up to (W+1)/2 bits, 32 by default.
  localparam int LO_W = (W + 1) / 2;
  logic [W-1:0] op_a, op_b;
  logic [LO_W-1:0] ma, mb;
  logic [2*LO_W-1:0] prod;
  logic [W2-1:0] prod_sh;
  always_comb begin
    op_a = (state == ST_MUL1) ? reciprocal : q1;
    op_b = (state == ST_MUL1) ? nh : dn;
    ma = part[0] ? LO_W'(op_a[W-1:LO_W]) : op_a[LO_W-1:0];
    mb = part[1] ? LO_W'(op_b[W-1:LO_W]) : op_b[LO_W-1:0];
    prod = ma * mb;
    prod_sh = W2'(prod) << (LO_W * (32'(part[0]) + 32'(part[1])));
  end

  logic [W-1:0] r0, r1, q1a, q1b, r2, q1c, q0s;
  logic [W2-1:0] sum1;
  always_comb begin
    sum1 = acc + {nh, nl};
    r0 = nl - acc[W-1:0];
    if (r0 > q0) begin
      q1a = q1 - W'(1);
      r1 = r0 + dn;
    end else begin
      q1a = q1;
      r1 = r0;
    end
    if (r1 >= dn) begin
      q1b = q1a + W'(1);
      r2 = r1 - dn;
    end else begin
      q1b = q1a;
      r2 = r1;
    end
    q1c = q1b;
    q0s = r2 >> sh;
  end

  logic out_free, out_load;
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == ST_DONE) && out_free;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      part <= 2'd0;
      divisor <= W'(1);
      norm_shift <= SHIFT_W'(63);
      reciprocal <= '1;
      run_rem <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIVISOR:    divisor <= cfg_data[W-1:0];
          REG_NORM_SHIFT: norm_shift <= cfg_data[SHIFT_W-1:0];
          REG_RECIPROCAL: reciprocal <= cfg_data[W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            nh <= pre_sh[W2-1:W];
            nl <= pre_sh[W-1:0];
            dn <= divisor << s_eff;
            sh <= s_eff;
            fin <= final_word;
            acc <= '0;
            part <= 2'd0;
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          acc <= acc + prod_sh;
          part <= part + 2'd1;
          if (part == 2'd3) state <= ST_ADD1;
        end
        ST_ADD1: begin
          q0 <= sum1[W-1:0];
          q1 <= sum1[W2-1:W] + W'(1);
          acc <= '0;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          acc <= acc + prod_sh;
          part <= part + 2'd1;
          if (part == 2'd3) state <= ST_FIX;
        end
        ST_FIX: begin
          q1 <= q1c;
          nl <= q0s;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            quotient_word <= q1;
            remainder <= nl;
            final_out <= fin;
            run_rem <= fin ? '0 : nl;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/mwdiv_checker.sv */
// ----------------------------------------------------------------------------
// Multiword divider checker
// Port-level checks of the divider's handshakes and sequencing.
// ----------------------------------------------------------------------------
module mwdiv_checker #(
  parameter int WORD_BITS = mwdiv_pkg::WORD_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] quotient_word,
  input logic [WORD_BITS-1:0] remainder
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready right after a word");
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 !$rose(out_valid)) else $error("result too early");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient_word) && $stable(remainder))
    else $error("stalled result changed");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");
endmodule

bind multiword_divide_by_word mwdiv_checker #(.WORD_BITS(WORD_BITS)) u_mwdiv_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .quotient_word(quotient_word), .remainder(remainder)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multiword divide by word testbench
// Streams multiword dividends through the divider under several divisor
// settings, predicts every quotient word and remainder, and checks them.
// ----------------------------------------------------------------------------

class div_scoreboard;
  logic [63:0] divisor_r;
  logic [5:0] shift_r;
  logic [63:0] recip_r;
  logic [63:0] run_rem;
  logic [63:0] exp_quo[$];
  logic [63:0] exp_rem[$];
  logic exp_fin[$];
  int errors;

  function void reset_state();
    divisor_r = 64'd1;
    shift_r = 6'd63;
    recip_r = '1;
    run_rem = '0;
    exp_quo.delete();
    exp_rem.delete();
    exp_fin.delete();
  endfunction

  function void note_word(logic [63:0] word, logic fin);
    logic [63:0] dn, nh, nl, q1, q0, r, rem;
    logic [127:0] prod;
    int s;
    s = shift_r;
    dn = divisor_r << s;
    nh = (run_rem << s) | ((s == 0) ? 64'd0 : (word >> (64 - s)));
    nl = word << s;
    prod = {64'd0, recip_r} * {64'd0, nh};
    q0 = prod[63:0] + nl;
    q1 = prod[127:64] + nh + ((q0 < nl) ? 64'd1 : 64'd0) + 64'd1;
    r = nl - q1 * dn;
    if (r > q0) begin
      q1 = q1 - 64'd1;
      r = r + dn;
    end
    if (r >= dn) begin
      q1 = q1 + 64'd1;
      r = r - dn;
    end
    rem = r >> s;
    exp_quo.push_back(q1);
    exp_rem.push_back(rem);
    exp_fin.push_back(fin);
    run_rem = fin ? 64'd0 : rem;
  endfunction

  function int pending();
    return exp_quo.size();
  endfunction
endclass

module tb_top;
  import mwdiv_pkg::*;

  logic clk, rst, cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, final_word, out_valid, out_ready, final_out;
  logic [63:0] dividend_word, quotient_word, remainder;
  div_scoreboard sb;
  int idle_cycles;
  bit hold_off, done;

  multiword_divide_by_word uut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    sb.errors++;
  endtask

  task automatic check_result();
    if (sb.pending() == 0) begin
      report("unexpected word", quotient_word, 64'd0);
    end else begin
      if (quotient_word !== sb.exp_quo[0]) report("quotient", quotient_word, sb.exp_quo[0]);
      if (remainder !== sb.exp_rem[0]) report("remainder", remainder, sb.exp_rem[0]);
      if (final_out !== sb.exp_fin[0]) begin
        report("final", 64'(final_out), 64'(sb.exp_fin[0]));
      end
      void'(sb.exp_quo.pop_front());
      void'(sb.exp_rem.pop_front());
      void'(sb.exp_fin.pop_front());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_word(dividend_word, final_word);
    if (!rst && out_valid && out_ready) check_result();
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stall pattern with an occasional long hold-off.
  initial begin
    out_ready = 0;
    @(negedge clk);
    while (!done) begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) < 3);
        @(negedge clk);
      end
    end
    out_ready <= 1;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we = 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      REG_DIVISOR: sb.divisor_r = val;
      REG_NORM_SHIFT: sb.shift_r = val[5:0];
      REG_RECIPROCAL: sb.recip_r = val;
      default: ;
    endcase
  endtask

  task automatic set_divisor(logic [63:0] d);
    logic [127:0] num;
    logic [63:0] dn;
    int s;
    s = 0;
    while (!d[63 - s]) s++;
    dn = d << s;
    num = ~128'd0;
    num = num / {64'd0, dn};
    write_reg(REG_DIVISOR, d);
    write_reg(REG_NORM_SHIFT, 64'(s));
    write_reg(REG_RECIPROCAL, num[63:0]);
  endtask

  task automatic send_word(logic [63:0] w, logic fin);
    in_valid = 1;
    dividend_word <= w;
    final_word <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  // Sends a word, sometimes after a random gap between bursts.
  int burst_left;
  task automatic offer(logic [63:0] w, logic fin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    burst_left--;
    send_word(w, fin);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rnd_divisor();
    logic [63:0] d;
    case ($urandom_range(0, 4))
      0: d = 64'd1;
      1: d = '1;
      2: d = rnd64() >> $urandom_range(0, 63);
      default: d = rnd64();
    endcase
    return (d == 0) ? 64'd3 : d;
  endfunction

  initial begin
    logic [63:0] w;
    int n, len;
    sb = new();
    sb.errors = 0;
    sb.reset_state();
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    dividend_word = '0;
    final_word = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Reset configuration first: divide by one.
    offer('1, 0);
    offer(64'd0, 0);
    offer(64'h8000_0000_0000_0001, 1);
    drain();

    set_divisor('1);
    offer('1, 0);
    offer(64'hffff_ffff_ffff_fffe, 0);
    offer('1, 1);
    offer(64'd0, 1);
    drain();

    set_divisor(64'd7);
    offer('1, 0);
    offer('1, 0);
    offer(64'd0, 1);
    drain();

    set_divisor(64'h8000_0000_0000_0000);
    offer(64'h1234_5678_9abc_def0, 0);
    offer('1, 1);
    drain();

    // A mismatched setting still follows the literal step, with zero divisor too.
    write_reg(REG_DIVISOR, 64'd0);
    write_reg(REG_NORM_SHIFT, 64'd0);
    write_reg(REG_RECIPROCAL, 64'h5555_aaaa_5555_aaaa);
    offer(rnd64(), 0);
    offer('1, 1);
    drain();
    write_reg(REG_DIVISOR, 64'd12345);
    write_reg(REG_NORM_SHIFT, 64'd17);
    write_reg(REG_RECIPROCAL, rnd64());
    offer(rnd64(), 0);
    offer(rnd64(), 1);
    drain();

    n = 0;
    while (n < 1200) begin
      set_divisor(rnd_divisor());
      if ($urandom_range(0, 2) == 0) hold_off = 1;
      repeat ($urandom_range(2, 8)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 7))
            0: w = '1;
            1: w = '0;
            default: w = rnd64();
          endcase
          offer(w, i == len - 1);
          n++;
        end
      end
      drain();
    end

    done = 1;
    drain();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
